// ===== design/tws_pkg.sv =====
// Shared types and codes for the two-wire bus frame sniffer.
`timescale 1ns / 1ps

package tws_pkg;

   localparam int unsigned BitsPerByte = 8;
   localparam int unsigned BitIdxW    = $clog2(BitsPerByte);

   // Pin event kinds on the request side
   localparam logic MODE_CLK = 1'b0;
   localparam logic MODE_IO  = 1'b1;

   // Event codes on the response side
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   typedef struct packed {
      logic mode;
      logic clk_level;
      logic io_level;
   } req_type;

   typedef struct packed {
      logic [1:0]             event_kind;
      logic [BitsPerByte-1:0] data_byte;
   } rsp_type;

   // Decoder result toward the output stage
   typedef struct packed {
      logic    hit;
      rsp_type rsp;
   } dec_result_type;

endpackage

// ===== design/tws_decoder.sv =====
// Frame decoder: framing state and per-event next-state and result logic.
`timescale 1ns / 1ps

module tws_decoder
   import tws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           fire,
   input  req_type        req,
   output dec_result_type result
);

   logic                   last_io_ff, last_io_in;
   logic                   in_frame_ff, in_frame_in;
   logic                   start_pending_ff, start_pending_in;
   logic [BitIdxW-1:0]     bit_count_ff, bit_count_in;
   logic [BitsPerByte-1:0] shift_byte_ff, shift_byte_in;
   logic                   frame_now;
   logic [BitsPerByte-1:0] byte_now;

   always_comb begin
      last_io_in       = last_io_ff;
      in_frame_in      = in_frame_ff;
      start_pending_in = start_pending_ff;
      bit_count_in     = bit_count_ff;
      shift_byte_in    = shift_byte_ff;
      result           = '0;
      frame_now        = in_frame_ff;
      byte_now         = shift_byte_ff | ({{(BitsPerByte-1){1'b0}}, req.io_level} << bit_count_ff);

      if (enable) begin
         if (req.mode == MODE_CLK) begin
            // confirm a pending start before sampling the bit
            if (start_pending_ff) begin
               start_pending_in         = 1'b0;
               in_frame_in              = 1'b1;
               frame_now                = 1'b1;
               result.hit               = 1'b1;
               result.rsp.event_kind    = KIND_START;
            end
            if (frame_now) begin
               if (bit_count_ff == BitIdxW'(BitsPerByte - 1)) begin
                  result.hit            = 1'b1;
                  result.rsp.event_kind = KIND_DATA;
                  result.rsp.data_byte  = byte_now;
                  bit_count_in          = '0;
                  shift_byte_in         = '0;
               end else begin
                  bit_count_in          = bit_count_ff + 1'b1;
                  shift_byte_in         = byte_now;
               end
            end
         end else begin
            if (req.clk_level) begin
               if (last_io_ff && !req.io_level) begin
                  if (!in_frame_ff && !start_pending_ff) begin
                     bit_count_in     = '0;
                     shift_byte_in    = '0;
                     start_pending_in = 1'b1;
                  end
               end else if (!last_io_ff && req.io_level) begin
                  if (in_frame_ff) begin
                     in_frame_in           = 1'b0;
                     bit_count_in          = '0;
                     shift_byte_in         = '0;
                     result.hit            = 1'b1;
                     result.rsp.event_kind = KIND_STOP;
                  end else begin
                     start_pending_in = 1'b0;
                  end
               end
            end
            last_io_in = req.io_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_io_ff       <= 1'b1;
         in_frame_ff      <= 1'b0;
         start_pending_ff <= 1'b0;
         bit_count_ff     <= '0;
         shift_byte_ff    <= '0;
      end else if (fire) begin
         last_io_ff       <= last_io_in;
         in_frame_ff      <= in_frame_in;
         start_pending_ff <= start_pending_in;
         bit_count_ff     <= bit_count_in;
         shift_byte_ff    <= shift_byte_in;
      end
   end

endmodule

// ===== design/tws_out_stage.sv =====
// Output register for decoded events, with upstream ready generation.
`timescale 1ns / 1ps

module tws_out_stage
   import tws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  dec_result_type result,
   output logic           room,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_payload
);

   logic    valid_ff, valid_in;
   rsp_type payload_ff;
   logic    load;

   assign room     = !valid_ff || rsp_ready;
   assign load     = fire && result.hit;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result.rsp;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// ===== design/two_wire_bus_frame_sniffer.sv =====
// Top level of the two-wire bus frame sniffer.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake            | Carries
// --------+-----------+----------------------+-------------------------------
// req_    | in        | req_valid/req_ready  | pin event (mode, clk, io)
// rsp_    | out       | rsp_valid/rsp_ready  | event kind and data byte
// csr_    | in        | csr_valid/csr_ready  | sniff_enable write data
//
// One pin event is accepted per cycle while req_ready is high; its result,
// if any, shows on rsp_ on the next cycle from the output register.
// req_ready is low only while a result sits unaccepted in the output register.
// Reset (synchronous, active high) clears the framing state, drops any
// pending result and disables sniffing; last IO reads as idle high.
// csr_ is always ready and takes effect on the following transaction.

module two_wire_bus_frame_sniffer
   import tws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic           sniff_enable_ff;
   logic           room;
   logic           req_fire;
   dec_result_type result;

   // Enable register: write on every csr transaction
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sniff_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         sniff_enable_ff <= csr_data;
      end
   end

   // Take a transaction whenever the output register can hold its result
   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;

   tws_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .enable (sniff_enable_ff),
      .fire   (req_fire),
      .req    (req_payload),
      .result (result)
   );

   tws_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .result      (result),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/tws_checker.sv =====
// Port-level checks for the two-wire bus frame sniffer, bound to the top level.
`timescale 1ns / 1ps

module tws_checker
   import tws_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   a_no_data_on_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind != KIND_DATA |-> rsp_payload.data_byte == '0)
      else $error("start or stop carries nonzero data");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled while output is free");

   // A response only appears after a request transaction
   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response raised without a request transaction");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind two_wire_bus_frame_sniffer tws_checker u_tws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
